/* design/ptrs_pkg.sv */
`timescale 1ns / 1ps
package ptrs_pkg;

  localparam int AVG_DEPTH_DEF   = 50;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int PCT_FULL        = 25600;
  localparam int PCT_ONE         = 256;
  localparam int MIN_REGEN_RPM   = 100;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POT_RANGE_A  = 3'd0,
    REG_POT_RANGE_B  = 3'd1,
    REG_DEAD_ZONE    = 3'd2,
    REG_THROTTLE_MAX = 3'd3,
    REG_REGEN_MAX    = 3'd4,
    REG_REGEN_BRAKE  = 3'd5,
    REG_SPEED_BOUNDS = 3'd6,
    REG_SPEED_SLEW   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_NEUTRAL = 2'd0,
    CLS_BRAKE   = 2'd1,
    CLS_PEDAL   = 2'd2
  } item_class_t;

  typedef struct packed {
    logic [23:0] pot_range_a;
    logic [23:0] pot_range_b;
    logic [14:0] dead_zone;
    logic [14:0] throttle_max;
    logic signed [15:0] regen_max;
    logic signed [15:0] regen_brake;
    logic [31:0] regen_speed_bounds;
    logic [14:0] speed_slew;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_DIV,
    ST_DZ_DIV,
    ST_DZ_WAIT,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_AVG_DIV,
    ST_AVG_CMP,
    ST_TAPER_MUL,
    ST_TAPER_DIV,
    ST_FWD_MUL,
    ST_FWD_DIV,
    ST_FWD_ADD,
    ST_DONE
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v < -48'sd32768) return -16'sd32768;
    if (v > 48'sd32767) return 16'sd32767;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat_pct(input logic signed [47:0] v);
    if (v < -48'sd25600) return -16'sd25600;
    if (v > 48'sd25600) return 16'sd25600;
    return v[15:0];
  endfunction

endpackage

/* design/ptrs_if.sv */
`timescale 1ns / 1ps
interface ptrs_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pedal_sample;
  logic                   pedal_select;
  logic                   brake_pressed;
  logic signed [15:0]     motor_speed;
  logic signed [1:0]      drive_direction;
  modport source (output valid, pedal_sample, pedal_select, brake_pressed, motor_speed,
                  drive_direction, input ready);
  modport sink (input valid, pedal_sample, pedal_select, brake_pressed, motor_speed,
                drive_direction, output ready);
endinterface

interface ptrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] torque_request;
  logic signed [1:0]  pedal_intent;
  modport source (output valid, torque_request, pedal_intent, input ready);
  modport sink (input valid, torque_request, pedal_intent, output ready);
endinterface

/* design/ptrs_divider.sv */
`timescale 1ns / 1ps
module ptrs_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] dividend,
  input  logic signed [47:0] divisor,
  output logic               done,
  output logic signed [47:0] quotient
);
  import ptrs_pkg::*;

  logic [47:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [48:0] trial;
  logic [47:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[46:0], quo_r[47]};
    trial    = {1'b0, shifted} - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = dividend[47] ? 48'(-dividend) : dividend;
      den_nxt  = divisor[47] ? 48'(-divisor) : divisor;
      neg_nxt  = dividend[47] ^ divisor[47];
      cnt_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[46:0], ~trial[48]};
      rem_nxt = trial[48] ? shifted : trial[47:0];
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? 48'(-quo_r) : quo_r;
endmodule

/* design/ptrs_front.sv */
`timescale 1ns / 1ps
module ptrs_front #(
  parameter int SAMPLE_BITS = ptrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  ptrs_in_if.sink                 in_ch,
  input  ptrs_pkg::cfg_t          cfg,
  output logic                    q_push,
  output ptrs_pkg::item_class_t   q_cls,
  output logic [SAMPLE_BITS-1:0]  q_sample,
  output logic [23:0]             q_range,
  output logic signed [1:0]       q_dir,
  output logic [15:0]             q_speed,
  input  logic                    q_full
);
  import ptrs_pkg::*;

  logic [15:0] fspeed_r, fspeed_nxt;
  logic [16:0] aspeed;
  logic signed [17:0] diff;
  logic [17:0] adiff;

  always_comb begin
    aspeed = in_ch.motor_speed[15] ? 17'(-$signed({in_ch.motor_speed[15], in_ch.motor_speed}))
                                   : {1'b0, in_ch.motor_speed};
    diff   = $signed({1'b0, aspeed}) - $signed({2'b0, fspeed_r});
    adiff  = diff[17] ? 18'(-diff) : diff;
    if (adiff > {3'b0, cfg.speed_slew})
      fspeed_nxt = (diff > 0) ? 16'(fspeed_r + cfg.speed_slew) : 16'(fspeed_r - cfg.speed_slew);
    else
      fspeed_nxt = aspeed[15:0];
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_sample    = in_ch.pedal_sample;
  assign q_range     = in_ch.pedal_select ? cfg.pot_range_b : cfg.pot_range_a;
  assign q_dir       = in_ch.drive_direction;
  assign q_speed     = fspeed_nxt;
  assign q_cls       = (in_ch.drive_direction == 2'sd0) ? CLS_NEUTRAL :
                       in_ch.brake_pressed ? CLS_BRAKE : CLS_PEDAL;

  always_ff @(posedge clk) begin
    if (!rst_n) fspeed_r <= '0;
    else if (q_push) fspeed_r <= fspeed_nxt;
  end
endmodule

/* design/ptrs_back.sv */
`timescale 1ns / 1ps
module ptrs_back #(
  parameter int AVG_DEPTH   = ptrs_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = ptrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptrs_pkg::cfg_t         cfg,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  ptrs_pkg::item_class_t  q_cls,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  input  logic [23:0]            q_range,
  input  logic signed [1:0]      q_dir,
  input  logic [15:0]            q_speed,
  ptrs_out_if.source             out_ch
);
  import ptrs_pkg::*;

  localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  // reciprocal of the history depth, exact for sums below 2^24
  localparam int AVG_SHIFT = 24 + $clog2(AVG_DEPTH);
  localparam logic [25:0] AVG_RECIP =
    26'(((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
  // full scale split as 2^10 * 25, reciprocal of 25 exact below 2^21
  localparam int FWD_PRE = 10;
  localparam int FWD_REST = PCT_FULL >> FWD_PRE;
  localparam int FWD_K = 21 + $clog2(FWD_REST);
  localparam logic [21:0] FWD_RECIP =
    22'(((64'd1 << FWD_K) + 64'(FWD_REST) - 64'd1) / 64'(FWD_REST));

  back_state_t st_r, st_nxt;
  logic [AVG_DEPTH-1:0] hvalid_r;
  logic signed [15:0] hist_mem [AVG_DEPTH];
  logic signed [15:0] hrd_r;
  logic [PW-1:0] ptr_r;
  logic signed [23:0] sum_r;
  logic signed [1:0] intent_r;
  logic signed [15:0] p_r, rl_r, res_r, avg_r;
  logic signed [47:0] acc_r;
  logic out_v_r;
  logic signed [1:0] out_i_r;
  logic signed [15:0] out_t_r;

  logic div_start;
  logic signed [47:0] div_a, div_b, div_q;
  logic div_done;

  ptrs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q)
  );

  logic signed [13:0] pmin, pmax;
  logic signed [16:0] end_s, full_s, spd_s, dz_s;
  logic signed [15:0] limit;
  logic signed [15:0] hold;
  logic signed [23:0] new_sum;
  logic [23:0] sum_mag;
  logic [49:0] avg_prod;
  logic [16:0] avg_mag;
  logic signed [15:0] avg;
  logic signed [16:0] change;
  logic [47:0] fwd_mag;
  logic [42:0] fwd_prod;
  logic [16:0] fwd_qmag;
  logic signed [47:0] fwd_q;

  always_comb begin
    pmin   = $signed({2'b0, q_range[11:0]});
    pmax   = $signed({2'b0, q_range[23:12]});
    end_s  = $signed({1'b0, cfg.regen_speed_bounds[15:0]});
    full_s = $signed({1'b0, cfg.regen_speed_bounds[31:16]});
    spd_s  = $signed({1'b0, q_speed});
    dz_s   = $signed({2'b0, cfg.dead_zone});
    limit  = (q_cls == CLS_BRAKE) ? cfg.regen_brake : cfg.regen_max;
    hold   = hvalid_r[ptr_r] ? hrd_r : 16'sd0;
    new_sum = sum_r - 24'(hold) + 24'(p_r);
    // average truncated toward zero
    sum_mag  = sum_r[23] ? 24'(-sum_r) : 24'(sum_r);
    avg_prod = 50'(sum_mag) * 50'(AVG_RECIP);
    avg_mag  = 17'(avg_prod >> AVG_SHIFT);
    avg      = sum_r[23] ? 16'(~avg_mag + 17'd1) : avg_mag[15:0];
    change   = 17'(p_r) - 17'(avg_r);
    // forward scaling by full scale, truncated toward zero
    fwd_mag  = acc_r[47] ? 48'(-acc_r) : 48'(acc_r);
    fwd_prod = 43'(fwd_mag[30:FWD_PRE]) * 43'(FWD_RECIP);
    fwd_qmag = 17'(fwd_prod >> FWD_K);
    fwd_q    = acc_r[47] ? 48'd0 - 48'(fwd_qmag) : 48'(fwd_qmag);
  end

  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    q_pop     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cls == CLS_NEUTRAL) st_nxt = ST_DONE;
          else if (q_cls == CLS_BRAKE) st_nxt = ST_TAPER_MUL;
          else if (pmax == pmin) st_nxt = ST_DZ_DIV;
          else begin
            div_start = 1'b1;
            div_a = 48'(($signed({1'b0, {(16-SAMPLE_BITS){1'b0}}, q_sample}) - pmin)
                        * 32'sd25600);
            div_b = 48'(pmax - pmin);
            st_nxt = ST_NORM_DIV;
          end
        end
      end
      ST_NORM_DIV: if (div_done) st_nxt = ST_DZ_DIV;
      ST_DZ_DIV: begin
        if (cfg.dead_zone >= 15'd25600 || 17'(p_r) < dz_s) st_nxt = ST_HIST_RD;
        else begin
          div_start = 1'b1;
          div_a = 48'((17'(p_r) - dz_s) * 32'sd25600);
          div_b = 48'sd25600 - 48'(dz_s);
          st_nxt = ST_DZ_WAIT;
        end
      end
      ST_DZ_WAIT: if (div_done) st_nxt = ST_HIST_RD;
      ST_HIST_RD: st_nxt = ST_HIST_WR;
      ST_HIST_WR: st_nxt = ST_AVG_DIV;
      ST_AVG_DIV: st_nxt = ST_AVG_CMP;
      ST_AVG_CMP: st_nxt = ST_TAPER_MUL;
      ST_TAPER_MUL: begin
        if (spd_s < 17'sd100 || spd_s < end_s || spd_s >= full_s) st_nxt = ST_FWD_MUL;
        else begin
          div_start = 1'b1;
          div_a = 48'((spd_s - end_s) * limit);
          div_b = 48'(full_s - end_s);
          st_nxt = ST_TAPER_DIV;
        end
      end
      ST_TAPER_DIV: if (div_done) st_nxt = ST_FWD_MUL;
      ST_FWD_MUL: begin
        if (q_cls == CLS_PEDAL && q_dir == 2'sd1) st_nxt = ST_FWD_DIV;
        else st_nxt = ST_DONE;
      end
      ST_FWD_DIV: st_nxt = ST_FWD_ADD;
      ST_FWD_ADD: st_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          q_pop = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      hvalid_r <= '0;
      ptr_r    <= '0;
      sum_r    <= '0;
      intent_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && (!out_v_r || out_ch.ready)) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          p_r  <= '0;
          rl_r <= '0;
          res_r <= '0;
        end
        ST_NORM_DIV: if (div_done) p_r <= sat16(div_q);
        ST_DZ_DIV: begin
          if (cfg.dead_zone >= 15'd25600 || 17'(p_r) < dz_s) p_r <= '0;
        end
        ST_DZ_WAIT: if (div_done) p_r <= sat16(div_q);
        ST_HIST_RD: hrd_r <= hist_mem[ptr_r];
        ST_HIST_WR: begin
          hist_mem[ptr_r] <= p_r;
          hvalid_r[ptr_r] <= 1'b1;
          sum_r <= new_sum;
          ptr_r <= (ptr_r == PW'(AVG_DEPTH - 1)) ? '0 : PW'(ptr_r + 1'b1);
        end
        ST_AVG_DIV: avg_r <= avg;
        ST_AVG_CMP: begin
          if (change < -17'sd256) intent_r <= -2'sd1;
          else if (change > 17'sd256) intent_r <= 2'sd1;
          else p_r <= avg_r;
        end
        ST_TAPER_MUL: begin
          if (spd_s < 17'sd100 || spd_s < end_s) rl_r <= '0;
          else rl_r <= limit;
        end
        ST_TAPER_DIV: if (div_done) rl_r <= div_q[15:0];
        ST_FWD_MUL: begin
          if (q_cls == CLS_PEDAL && q_dir == 2'sd1)
            acc_r <= 48'(p_r * ($signed({2'b0, cfg.throttle_max}) - 17'(rl_r)));
          else if (q_cls == CLS_BRAKE) res_r <= rl_r;
          else res_r <= p_r;
        end
        ST_FWD_DIV: acc_r <= fwd_q;
        ST_FWD_ADD: res_r <= sat_pct(48'(rl_r) + acc_r);
        ST_DONE: begin
          if (!out_v_r || out_ch.ready) begin
            out_t_r <= sat_pct(48'(res_r));
            out_i_r <= intent_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.torque_request = out_t_r;
  assign out_ch.pedal_intent   = out_i_r;

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_DONE) else $error("pop outside done");
  a_out_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_v_r) else $error("result lost");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(AVG_DEPTH - 1)) else $error("pointer overrun");
endmodule

/* design/pedal_throttle_regen_shaper.sv */
`timescale 1ns / 1ps
// pedal throttle shaper with regen taper
// in_ channel: one word per pedal sample (pedal, select, brake, speed, direction)
// out_ channel: one word per input word (torque request Q8.8, pedal intent)
// cfg_ port: write enable, index, data; write only while idle
// a front stage slews the filtered speed and classifies each word, a two
// entry queue hands it to the back stage, which runs the shared 48-step
// serial divider for normalization, dead zone and taper; the average and the
// forward scaling use reciprocal multiplies
// a neutral word uses no division, a brake word at most the taper
// division, a pedal word up to three plus history and scaling steps
// throughput: one word at a time in the back stage
// the front keeps accepting while the queue has room
// when the receiver stalls the result holds in the output register and the
// back stage waits, then the queue fills and in_ready drops
// reset clears filtered speed, history valid bits, sum, pointer, intent,
// queue and output valid, and loads register defaults
module pedal_throttle_regen_shaper #(
  parameter int AVG_DEPTH   = ptrs_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = ptrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ptrs_in_if.sink                           in_ch,
  ptrs_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ptrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ptrs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pot_range_a        <= 24'd16773120;
      cfg_r.pot_range_b        <= 24'd16773120;
      cfg_r.dead_zone          <= '0;
      cfg_r.throttle_max       <= 15'd25600;
      cfg_r.regen_max          <= '0;
      cfg_r.regen_brake        <= '0;
      cfg_r.regen_speed_bounds <= '0;
      cfg_r.speed_slew         <= 15'd100;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POT_RANGE_A:  cfg_r.pot_range_a        <= cfg_data[23:0];
        REG_POT_RANGE_B:  cfg_r.pot_range_b        <= cfg_data[23:0];
        REG_DEAD_ZONE:    cfg_r.dead_zone          <= cfg_data[14:0];
        REG_THROTTLE_MAX: cfg_r.throttle_max       <= cfg_data[14:0];
        REG_REGEN_MAX:    cfg_r.regen_max          <= cfg_data[15:0];
        REG_REGEN_BRAKE:  cfg_r.regen_brake        <= cfg_data[15:0];
        REG_SPEED_BOUNDS: cfg_r.regen_speed_bounds <= cfg_data;
        REG_SPEED_SLEW:   cfg_r.speed_slew         <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic push, pop, full;
  item_class_t f_cls;
  logic [SAMPLE_BITS-1:0] f_sample;
  logic [23:0] f_range;
  logic signed [1:0] f_dir;
  logic [15:0] f_speed;

  ptrs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg_r), .q_push(push), .q_cls(f_cls),
    .q_sample(f_sample), .q_range(f_range), .q_dir(f_dir), .q_speed(f_speed), .q_full(full)
  );

  localparam int QW = 2 + SAMPLE_BITS + 24 + 2 + 16;
  logic [QW-1:0] q_mem [QUEUE_DEPTH];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic [QW-1:0] q_head;

  assign full   = (q_cnt_r == 2'(QUEUE_DEPTH));
  assign q_head = q_mem[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
    if (push) q_mem[q_wp_r] <= {f_cls, f_sample, f_range, f_dir, f_speed};
  end

  ptrs_back #(.AVG_DEPTH(AVG_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_cnt_r != 2'd0), .q_pop(pop),
    .q_cls(item_class_t'(q_head[QW-1 -: 2])),
    .q_sample(q_head[QW-3 -: SAMPLE_BITS]),
    .q_range(q_head[41:18]), .q_dir(q_head[17:16]), .q_speed(q_head[15:0]),
    .out_ch(out_ch)
  );
endmodule

/* tb/tb_pedal_throttle_regen_shaper.sv */
`timescale 1ns / 1ps
module tb_pedal_throttle_regen_shaper;
  import ptrs_pkg::*;

  localparam int HIST_DEPTH = 50;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic signed [15:0] torque;
    logic signed [1:0]  intent;
  } torque_word_t;

  class torque_scoreboard;
    cfg_t cfg;
    int speed_filt;
    int hist [HIST_DEPTH];
    int hist_sum;
    int hist_ptr;
    int intent_now;
    torque_word_t pending_words[$];
    int mismatches;

    function new();
      cfg.pot_range_a = 24'd16773120;
      cfg.pot_range_b = 24'd16773120;
      cfg.dead_zone = '0;
      cfg.throttle_max = 15'd25600;
      cfg.regen_max = '0;
      cfg.regen_brake = '0;
      cfg.regen_speed_bounds = '0;
      cfg.speed_slew = 15'd100;
      speed_filt = 0;
      foreach (hist[i]) hist[i] = 0;
      hist_sum = 0;
      hist_ptr = 0;
      intent_now = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_POT_RANGE_A:  cfg.pot_range_a = val[23:0];
        REG_POT_RANGE_B:  cfg.pot_range_b = val[23:0];
        REG_DEAD_ZONE:    cfg.dead_zone = val[14:0];
        REG_THROTTLE_MAX: cfg.throttle_max = val[14:0];
        REG_REGEN_MAX:    cfg.regen_max = val[15:0];
        REG_REGEN_BRAKE:  cfg.regen_brake = val[15:0];
        REG_SPEED_BOUNDS: cfg.regen_speed_bounds = val;
        REG_SPEED_SLEW:   cfg.speed_slew = val[14:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int regen_limit(int spd, int limit);
      int lo_rpm;
      int hi_rpm;
      lo_rpm = int'(cfg.regen_speed_bounds[15:0]);
      hi_rpm = int'(cfg.regen_speed_bounds[31:16]);
      if (spd < MIN_REGEN_RPM || spd < lo_rpm) return 0;
      if (spd < hi_rpm) return int'((longint'(spd - lo_rpm) * limit) / longint'(hi_rpm - lo_rpm));
      return limit;
    endfunction

    function void note_input(logic [11:0] smp, logic sel, logic brk,
                             logic signed [15:0] spd_in, logic signed [1:0] dir);
      logic [23:0] rng;
      int spd, diff, adiff, slew, res, pmin, pmax, dz, pct, avg, chg, rl;
      torque_word_t w;
      rng = sel ? cfg.pot_range_b : cfg.pot_range_a;
      spd = spd_in;
      if (spd < 0) spd = -spd;
      slew = int'(cfg.speed_slew);
      diff = spd - speed_filt;
      adiff = diff < 0 ? -diff : diff;
      if (adiff > slew) speed_filt += (spd > speed_filt) ? slew : -slew;
      else speed_filt = spd;
      res = 0;
      if (dir == 2'sd0) begin
        res = 0;
      end else if (brk) begin
        res = regen_limit(speed_filt, int'(cfg.regen_brake));
      end else begin
        pmin = int'(rng[11:0]);
        pmax = int'(rng[23:12]);
        dz = int'(cfg.dead_zone);
        pct = 0;
        if (pmax != pmin)
          pct = int'(clip((longint'(int'(smp) - pmin) * PCT_FULL) / longint'(pmax - pmin),
                          -32768, 32767));
        if (dz >= PCT_FULL || pct < dz) pct = 0;
        else pct = int'(clip((longint'(pct - dz) * PCT_FULL) / longint'(PCT_FULL - dz),
                             -32768, 32767));
        hist_sum -= hist[hist_ptr];
        hist[hist_ptr] = pct;
        hist_sum += pct;
        hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
        avg = hist_sum / HIST_DEPTH;
        chg = pct - avg;
        if (chg < -PCT_ONE) intent_now = -1;
        else if (chg > PCT_ONE) intent_now = 1;
        else pct = avg;
        rl = regen_limit(speed_filt, int'(cfg.regen_max));
        if (dir == 2'sd1)
          res = int'(clip(longint'(rl) +
                          (longint'(pct) * (longint'(cfg.throttle_max) - rl)) / PCT_FULL,
                          -PCT_FULL, PCT_FULL));
        else
          res = pct;
      end
      res = int'(clip(res, -PCT_FULL, PCT_FULL));
      w.torque = res[15:0];
      w.intent = intent_now[1:0];
      pending_words.push_back(w);
    endfunction

    function void check_output(logic signed [15:0] torque, logic signed [1:0] intent);
      torque_word_t w;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: torque %0d intent %0d", torque, intent);
        return;
      end
      w = pending_words.pop_front();
      if (torque !== w.torque || intent !== w.intent) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: torque exp %0d got %0d, intent exp %0d got %0d",
                   w.torque, torque, w.intent, intent);
      end
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int cycle_count = 0;
  int ready_left = 0;
  int cur_sample = 2048;
  torque_scoreboard sb;

  ptrs_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
  ptrs_out_if out_ch ();

  pedal_throttle_regen_shaper i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pedal_sample = '0;
    in_ch.pedal_select = 1'b0;
    in_ch.brake_pressed = 1'b0;
    in_ch.motor_speed = '0;
    in_ch.drive_direction = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL pedal_throttle_regen_shaper");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_ch.ready <= 1'b0;
          ready_left <= $urandom_range(0, 3);
        end
        2: begin
          out_ch.ready <= 1'b0;
          ready_left <= $urandom_range(8, 40);
        end
        3: begin
          out_ch.ready <= 1'b1;
          ready_left <= $urandom_range(30, 200);
        end
        default: begin
          out_ch.ready <= 1'b1;
          ready_left <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.pedal_sample, in_ch.pedal_select, in_ch.brake_pressed,
                    in_ch.motor_speed, in_ch.drive_direction);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_output(out_ch.torque_request, out_ch.pedal_intent);
  end

  task automatic set_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic load_config(logic [23:0] ra, logic [23:0] rb, logic [14:0] dz,
                             logic [14:0] tmax, logic [15:0] rmax, logic [15:0] rbrk,
                             logic [31:0] bounds, logic [14:0] slew);
    in_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_reg(REG_POT_RANGE_A, 32'(ra));
    set_reg(REG_POT_RANGE_B, 32'(rb));
    set_reg(REG_DEAD_ZONE, 32'(dz));
    set_reg(REG_THROTTLE_MAX, 32'(tmax));
    set_reg(REG_REGEN_MAX, 32'(rmax));
    set_reg(REG_REGEN_BRAKE, 32'(rbrk));
    set_reg(REG_SPEED_BOUNDS, bounds);
    set_reg(REG_SPEED_SLEW, 32'(slew));
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(logic [11:0] smp, logic sel, logic brk,
                           logic signed [15:0] spd, logic signed [1:0] dir);
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      9: gap = $urandom_range(5, 30);
      default: gap = $urandom_range(1, 3);
    endcase
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pedal_sample <= smp;
    in_ch.pedal_select <= sel;
    in_ch.brake_pressed <= brk;
    in_ch.motor_speed <= spd;
    in_ch.drive_direction <= dir;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(int count);
    logic [11:0] smp;
    logic signed [15:0] spd;
    logic signed [1:0] dir;
    logic brk;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        drain();
      end
      if ($urandom_range(0, 9) < 7) begin
        cur_sample = cur_sample + $urandom_range(0, 80) - 40;
        if ($urandom_range(0, 19) == 0) cur_sample = $urandom_range(0, 4095);
        if (cur_sample < 0) cur_sample = 0;
        if (cur_sample > 4095) cur_sample = 4095;
        smp = cur_sample[11:0];
      end else begin
        smp = 12'($urandom);
      end
      if ($urandom_range(0, 3) == 0) spd = 16'($urandom);
      else spd = 16'(int'($urandom_range(0, 6000)) - 3000);
      case ($urandom_range(0, 9))
        0: dir = 2'sd0;
        1: dir = -2'sd1;
        2: dir = -2'sd2;
        default: dir = 2'sd1;
      endcase
      brk = ($urandom_range(0, 5) == 0);
      send_word(smp, 1'($urandom_range(0, 1)), brk, spd, dir);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_random(40);

    load_config({12'd4000, 12'd100}, {12'd100, 12'd4000}, 15'd2560, 15'd25600,
                16'hE700, 16'hCE00, {16'd2000, 16'd300}, 15'd32767);
    send_word(12'd0, 1'b0, 1'b0, 16'sd0, 2'sd0);
    send_word(12'd100, 1'b0, 1'b0, 16'sd0, 2'sd1);
    send_word(12'd4000, 1'b0, 1'b0, 16'sd50, 2'sd1);
    send_word(12'd4095, 1'b0, 1'b0, 16'sd1000, 2'sd1);
    send_word(12'd0, 1'b0, 1'b0, 16'sd5000, 2'sd1);
    send_word(12'd300, 1'b0, 1'b0, 16'sd250, 2'sd1);
    send_word(12'd2000, 1'b1, 1'b0, 16'sd1200, 2'sd1);
    send_word(12'd4095, 1'b1, 1'b0, -16'sd32768, 2'sd1);
    send_word(12'd2000, 1'b0, 1'b0, 16'sd32767, -2'sd1);
    send_word(12'd3000, 1'b0, 1'b0, 16'sd800, -2'sd2);
    send_word(12'd3000, 1'b0, 1'b1, 16'sd50, 2'sd1);
    send_word(12'd3000, 1'b0, 1'b1, 16'sd1000, 2'sd1);
    send_word(12'd3000, 1'b0, 1'b1, 16'sd3000, -2'sd1);
    send_word(12'd3000, 1'b1, 1'b1, -16'sd200, 2'sd0);
    send_word(12'd3001, 1'b0, 1'b0, 16'sd1000, 2'sd1);
    send_word(12'd3000, 1'b0, 1'b0, 16'sd1000, 2'sd1);
    send_word(12'd2000, 1'b0, 1'b0, 16'sd1000, 2'sd1);

    load_config(24'h000000, 24'hFFF000, 15'h7FFF, 15'h7FFF, 16'h9C00, 16'h8000,
                32'hFFFF_0000, 15'd0);
    send_random(100);

    load_config(24'h000FFF, 24'h123123, 15'd0, 15'd0, 16'h7FFF, 16'h0000,
                32'h0000_FFFF, 15'h7FFF);
    send_random(100);

    for (int ph = 0; ph < 5; ph++) begin
      load_config(24'($urandom), 24'($urandom), 15'($urandom_range(0, 26000)),
                  15'($urandom_range(0, 25600)),
                  16'(-int'($urandom_range(0, 25600))), 16'(-int'($urandom_range(0, 25600))),
                  {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 1500))},
                  15'($urandom_range(0, 2000)));
      send_random(200);
    end

    in_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS pedal_throttle_regen_shaper");
    end else begin
      $display("FAIL pedal_throttle_regen_shaper");
    end
    $finish;
  end
endmodule

/* pedal_throttle_regen_shaper.f */
design/ptrs_pkg.sv
design/ptrs_if.sv
design/ptrs_divider.sv
design/ptrs_front.sv
design/ptrs_back.sv
design/pedal_throttle_regen_shaper.sv
tb/tb_pedal_throttle_regen_shaper.sv
